// File: sv/segment_intersection_2d_unit_macros.svh
// Assertion macros shared by the segment intersection unit.
`ifndef SEGMENT_INTERSECTION_2D_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SIS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment intersection check failed");

// Next-cycle implication, checked out of reset.
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment intersection check failed");

`endif

// File: sv/sis_pkg.sv
package sis_pkg;

  // Default coordinate width and number of fraction bits of the result.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

// File: sv/sis_front.sv
module sis_front #(
  parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sis_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_fire,
  input  logic signed [COORD_BITS-1:0]        a_start_x,
  input  logic signed [COORD_BITS-1:0]        a_start_y,
  input  logic signed [COORD_BITS-1:0]        a_end_x,
  input  logic signed [COORD_BITS-1:0]        a_end_y,
  input  logic signed [COORD_BITS-1:0]        b_start_x,
  input  logic signed [COORD_BITS-1:0]        b_start_y,
  input  logic signed [COORD_BITS-1:0]        b_end_x,
  input  logic signed [COORD_BITS-1:0]        b_end_y,
  output sis_pkg::ctl_t                       ctl_o,
  output logic [2*COORD_BITS+2:0]             div_o,
  output logic [2*COORD_BITS+2:0]             rem_x_o,
  output logic [2*COORD_BITS+2:0]             rem_y_o,
  output logic [COORD_BITS+FRAC_BITS:0]       num_x_o,
  output logic [COORD_BITS+FRAC_BITS:0]       num_y_o,
  output logic signed [COORD_BITS-1:0]        base_x_o,
  output logic signed [COORD_BITS-1:0]        base_y_o
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int PR_W  = 2 * COORD_BITS + 2;
  localparam int MAG_W = 2 * COORD_BITS + 3;
  localparam int P_W   = MAG_W + D_W;
  localparam int Q_W   = COORD_BITS + 1 + FRAC_BITS;

  // Stage one: edge vectors.
  logic                           v1_r;
  logic signed [D_W-1:0]          rx1_r, ry1_r, qx1_r, qy1_r, wx1_r, wy1_r;
  logic signed [COORD_BITS-1:0]   bx1_r, by1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rx1_r <= D_W'(a_end_x) - D_W'(a_start_x);
      ry1_r <= D_W'(a_end_y) - D_W'(a_start_y);
      qx1_r <= D_W'(b_end_x) - D_W'(b_start_x);
      qy1_r <= D_W'(b_end_y) - D_W'(b_start_y);
      wx1_r <= D_W'(b_start_x) - D_W'(a_start_x);
      wy1_r <= D_W'(b_start_y) - D_W'(a_start_y);
      bx1_r <= a_start_x;
      by1_r <= a_start_y;
    end
  end

  // Stage two: the six cross-product terms.
  logic                           v2_r;
  logic signed [PR_W-1:0]         m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [D_W-1:0]          rx2_r, ry2_r;
  logic signed [COORD_BITS-1:0]   bx2_r, by2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r  <= rx1_r * qy1_r;
      m1_r  <= ry1_r * qx1_r;
      m2_r  <= wx1_r * qy1_r;
      m3_r  <= wy1_r * qx1_r;
      m4_r  <= wx1_r * ry1_r;
      m5_r  <= wy1_r * rx1_r;
      rx2_r <= rx1_r;
      ry2_r <= ry1_r;
      bx2_r <= bx1_r;
      by2_r <= by1_r;
    end
  end

  // Stage three: determinant, numerators, exact range test and magnitudes.
  logic signed [MAG_W-1:0] det, ns, nt;
  logic                    hit;

  always_comb begin
    det = MAG_W'(m0_r) - MAG_W'(m1_r);
    ns  = MAG_W'(m2_r) - MAG_W'(m3_r);
    nt  = MAG_W'(m4_r) - MAG_W'(m5_r);
    if (det > 0) begin
      hit = (ns >= 0) && (ns <= det) && (nt >= 0) && (nt <= det);
    end else if (det < 0) begin
      hit = (ns <= 0) && (ns >= det) && (nt <= 0) && (nt >= det);
    end else begin
      hit = 1'b0;
    end
  end

  sis_pkg::ctl_t                  c3_r;
  logic [MAG_W-1:0]               mn3_r, md3_r;
  logic [D_W-1:0]                 mrx3_r, mry3_r;
  logic signed [COORD_BITS-1:0]   bx3_r, by3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r.valid <= 1'b0;
    end else if (en) begin
      c3_r.valid <= v2_r;
    end
    if (en) begin
      c3_r.hit   <= hit;
      c3_r.neg_x <= rx2_r[D_W-1];
      c3_r.neg_y <= ry2_r[D_W-1];
      mn3_r      <= ns[MAG_W-1] ? MAG_W'(-ns) : MAG_W'(ns);
      md3_r      <= det[MAG_W-1] ? MAG_W'(-det) : MAG_W'(det);
      mrx3_r     <= rx2_r[D_W-1] ? D_W'(-rx2_r) : D_W'(rx2_r);
      mry3_r     <= ry2_r[D_W-1] ? D_W'(-ry2_r) : D_W'(ry2_r);
      bx3_r      <= bx2_r;
      by3_r      <= by2_r;
    end
  end

  // Stage four: scaled numerators |num_s| * |r|.
  sis_pkg::ctl_t                  c4_r;
  logic [P_W-1:0]                 px4_r, py4_r;
  logic [MAG_W-1:0]               md4_r;
  logic signed [COORD_BITS-1:0]   bx4_r, by4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_r.valid <= 1'b0;
    end else if (en) begin
      c4_r.valid <= c3_r.valid;
    end
    if (en) begin
      c4_r.hit   <= c3_r.hit;
      c4_r.neg_x <= c3_r.neg_x;
      c4_r.neg_y <= c3_r.neg_y;
      px4_r      <= P_W'(mn3_r) * P_W'(mrx3_r);
      py4_r      <= P_W'(mn3_r) * P_W'(mry3_r);
      md4_r      <= md3_r;
      bx4_r      <= bx3_r;
      by4_r      <= by3_r;
    end
  end

  // Split the dividend: high part is the starting remainder, low part is shifted in.
  assign ctl_o    = c4_r;
  assign div_o    = md4_r;
  assign rem_x_o  = px4_r[P_W-1:D_W];
  assign rem_y_o  = py4_r[P_W-1:D_W];
  assign num_x_o  = Q_W'(px4_r[D_W-1:0]) << FRAC_BITS;
  assign num_y_o  = Q_W'(py4_r[D_W-1:0]) << FRAC_BITS;
  assign base_x_o = bx4_r;
  assign base_y_o = by4_r;

endmodule

// File: sv/sis_div_cell.sv
module sis_div_cell #(
  parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sis_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  sis_pkg::ctl_t                       ctl_i,
  input  logic [2*COORD_BITS+2:0]             div_i,
  input  logic [2*COORD_BITS+2:0]             rem_x_i,
  input  logic [2*COORD_BITS+2:0]             rem_y_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       num_x_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       num_y_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       quo_x_i,
  input  logic [COORD_BITS+FRAC_BITS:0]       quo_y_i,
  input  logic signed [COORD_BITS-1:0]        base_x_i,
  input  logic signed [COORD_BITS-1:0]        base_y_i,
  output sis_pkg::ctl_t                       ctl_o,
  output logic [2*COORD_BITS+2:0]             div_o,
  output logic [2*COORD_BITS+2:0]             rem_x_o,
  output logic [2*COORD_BITS+2:0]             rem_y_o,
  output logic [COORD_BITS+FRAC_BITS:0]       num_x_o,
  output logic [COORD_BITS+FRAC_BITS:0]       num_y_o,
  output logic [COORD_BITS+FRAC_BITS:0]       quo_x_o,
  output logic [COORD_BITS+FRAC_BITS:0]       quo_y_o,
  output logic signed [COORD_BITS-1:0]        base_x_o,
  output logic signed [COORD_BITS-1:0]        base_y_o
);

  localparam int MAG_W = 2 * COORD_BITS + 3;
  localparam int Q_W   = COORD_BITS + 1 + FRAC_BITS;

  // One restoring step per lane: bring down the next dividend bit and try to subtract.
  logic [MAG_W:0] trial_x, trial_y, dext, diff_x, diff_y;
  logic           ge_x, ge_y;

  always_comb begin
    dext    = {1'b0, div_i};
    trial_x = {rem_x_i, num_x_i[Q_W-1]};
    trial_y = {rem_y_i, num_y_i[Q_W-1]};
    ge_x    = trial_x >= dext;
    ge_y    = trial_y >= dext;
    diff_x  = ge_x ? trial_x - dext : trial_x;
    diff_y  = ge_y ? trial_y - dext : trial_y;
  end

  sis_pkg::ctl_t                  ctl_r;
  logic [MAG_W-1:0]               div_r, rem_x_r, rem_y_r;
  logic [Q_W-1:0]                 num_x_r, num_y_r, quo_x_r, quo_y_r;
  logic signed [COORD_BITS-1:0]   base_x_r, base_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
    if (en) begin
      ctl_r.hit   <= ctl_i.hit;
      ctl_r.neg_x <= ctl_i.neg_x;
      ctl_r.neg_y <= ctl_i.neg_y;
      div_r       <= div_i;
      rem_x_r     <= diff_x[MAG_W-1:0];
      rem_y_r     <= diff_y[MAG_W-1:0];
      num_x_r     <= {num_x_i[Q_W-2:0], 1'b0};
      num_y_r     <= {num_y_i[Q_W-2:0], 1'b0};
      quo_x_r     <= {quo_x_i[Q_W-2:0], ge_x};
      quo_y_r     <= {quo_y_i[Q_W-2:0], ge_y};
      base_x_r    <= base_x_i;
      base_y_r    <= base_y_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign div_o    = div_r;
  assign rem_x_o  = rem_x_r;
  assign rem_y_o  = rem_y_r;
  assign num_x_o  = num_x_r;
  assign num_y_o  = num_y_r;
  assign quo_x_o  = quo_x_r;
  assign quo_y_o  = quo_y_r;
  assign base_x_o = base_x_r;
  assign base_y_o = base_y_r;

endmodule

// File: sv/segment_intersection_2d_unit.sv
// Channel   Handshake               Word
// in_       in_valid / in_stall     two segments, eight signed coordinates
// out_      out_valid / out_stall   hit flag and crossing point in Q16.8
//
// One word is taken every cycle unless in_stall is high. A word passes four front
// stages, one divider cell per quotient bit and the output register; the row of
// divider cells makes up most of the pipeline depth.
// Reset is synchronous and clears only valid flags.
// The whole pipeline holds while the output register is full and stalled.

`include "segment_intersection_2d_unit_macros.svh"

module segment_intersection_2d_unit #(
  parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sis_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_BITS-1:0]          in_a_start_x,
  input  logic signed [COORD_BITS-1:0]          in_a_start_y,
  input  logic signed [COORD_BITS-1:0]          in_a_end_x,
  input  logic signed [COORD_BITS-1:0]          in_a_end_y,
  input  logic signed [COORD_BITS-1:0]          in_b_start_x,
  input  logic signed [COORD_BITS-1:0]          in_b_start_y,
  input  logic signed [COORD_BITS-1:0]          in_b_end_x,
  input  logic signed [COORD_BITS-1:0]          in_b_end_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_hit,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_x,
  output logic signed [COORD_BITS+FRAC_BITS-1:0] out_cross_y
);

  localparam int MAG_W = 2 * COORD_BITS + 3;
  localparam int Q_W   = COORD_BITS + 1 + FRAC_BITS;
  localparam int OUT_W = COORD_BITS + FRAC_BITS;

  // Pipeline advance.
  logic out_valid_r;
  logic en;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Chain links: index 0 is the front end, index Q_W the last cell.
  sis_pkg::ctl_t                  ctl    [Q_W+1];
  logic [MAG_W-1:0]               dv     [Q_W+1];
  logic [MAG_W-1:0]               rem_x  [Q_W+1];
  logic [MAG_W-1:0]               rem_y  [Q_W+1];
  logic [Q_W-1:0]                 num_x  [Q_W+1];
  logic [Q_W-1:0]                 num_y  [Q_W+1];
  logic [Q_W-1:0]                 quo_x  [Q_W+1];
  logic [Q_W-1:0]                 quo_y  [Q_W+1];
  logic signed [COORD_BITS-1:0]   base_x [Q_W+1];
  logic signed [COORD_BITS-1:0]   base_y [Q_W+1];

  sis_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_fire   (in_valid),
    .a_start_x (in_a_start_x),
    .a_start_y (in_a_start_y),
    .a_end_x   (in_a_end_x),
    .a_end_y   (in_a_end_y),
    .b_start_x (in_b_start_x),
    .b_start_y (in_b_start_y),
    .b_end_x   (in_b_end_x),
    .b_end_y   (in_b_end_y),
    .ctl_o     (ctl[0]),
    .div_o     (dv[0]),
    .rem_x_o   (rem_x[0]),
    .rem_y_o   (rem_y[0]),
    .num_x_o   (num_x[0]),
    .num_y_o   (num_y[0]),
    .base_x_o  (base_x[0]),
    .base_y_o  (base_y[0])
  );

  assign quo_x[0] = '0;
  assign quo_y[0] = '0;

  // Row of divider cells, one quotient bit each.
  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    sis_div_cell #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (ctl[i]),
      .div_i    (dv[i]),
      .rem_x_i  (rem_x[i]),
      .rem_y_i  (rem_y[i]),
      .num_x_i  (num_x[i]),
      .num_y_i  (num_y[i]),
      .quo_x_i  (quo_x[i]),
      .quo_y_i  (quo_y[i]),
      .base_x_i (base_x[i]),
      .base_y_i (base_y[i]),
      .ctl_o    (ctl[i+1]),
      .div_o    (dv[i+1]),
      .rem_x_o  (rem_x[i+1]),
      .rem_y_o  (rem_y[i+1]),
      .num_x_o  (num_x[i+1]),
      .num_y_o  (num_y[i+1]),
      .quo_x_o  (quo_x[i+1]),
      .quo_y_o  (quo_y[i+1]),
      .base_x_o (base_x[i+1]),
      .base_y_o (base_y[i+1])
    );
  end

  // Final offset: start point scaled to fixed point, plus or minus the quotient; zero on a miss.
  logic signed [OUT_W-1:0] bx_fix, by_fix, cx_nxt, cy_nxt;
  logic [OUT_W-1:0]        offs_x, offs_y;
  sis_pkg::ctl_t           last;

  always_comb begin
    last   = ctl[Q_W];
    bx_fix = OUT_W'(base_x[Q_W]) <<< FRAC_BITS;
    by_fix = OUT_W'(base_y[Q_W]) <<< FRAC_BITS;
    offs_x = quo_x[Q_W][OUT_W-1:0];
    offs_y = quo_y[Q_W][OUT_W-1:0];
    if (last.hit) begin
      cx_nxt = last.neg_x ? bx_fix - $signed(offs_x) : bx_fix + $signed(offs_x);
      cy_nxt = last.neg_y ? by_fix - $signed(offs_y) : by_fix + $signed(offs_y);
    end else begin
      cx_nxt = '0;
      cy_nxt = '0;
    end
  end

  // Output register.
  logic                    hit_r;
  logic signed [OUT_W-1:0] cx_r, cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= last.hit;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_cross_x = cx_r;
  assign out_cross_y = cy_r;

  // A miss always reports the origin.
  `SIS_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_cross_x == 0 && out_cross_y == 0)
  // An empty output register never holds back the input.
  `SIS_ASSERT_NOW(a_empty_accepts, !out_valid, !in_stall)
  // A held result keeps its hit flag.
  `SIS_ASSERT_NEXT(a_hold_hit, out_valid && out_stall, out_hit == $past(out_hit))

endmodule

// File: test/segment_intersection_2d_unit_tb.sv
`timescale 1ns / 1ps

module segment_intersection_2d_unit_tb;

  localparam int CB = sis_pkg::COORD_BITS_DEF;
  localparam int FB = sis_pkg::FRAC_BITS_DEF;
  localparam int OB = CB + FB;
  localparam int LATENCY = CB + FB + 6;
  localparam int N_RANDOM = 1450;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [OB-1:0] fixed_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct {
    logic   hit;
    fixed_t cx;
    fixed_t cy;
  } crossing_t;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  coord_t in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y;
  coord_t in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y;
  logic out_valid, out_stall, out_hit;
  fixed_t out_cross_x, out_cross_y;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int  mismatches;
  int  words_in, words_out, hits_seen;
  longint cycles;
  bit  stimulus_done;
  bit  hold_sender;

  segment_intersection_2d_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a_start_x(in_a_start_x), .in_a_start_y(in_a_start_y),
    .in_a_end_x(in_a_end_x), .in_a_end_y(in_a_end_y),
    .in_b_start_x(in_b_start_x), .in_b_start_y(in_b_start_y),
    .in_b_end_x(in_b_end_x), .in_b_end_y(in_b_end_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_hit(out_hit), .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Floor of n*m/d by long division; n <= d so the quotient stays small.
  function automatic longint unsigned scaled_quotient(longint unsigned n,
                                                      longint unsigned m,
                                                      longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q++;
      end
      if (m[i]) begin
        r = r + n;
        if (r >= d) begin
          r = r - d;
          q++;
        end
      end
    end
    return q;
  endfunction

  // One crossing coordinate: base plus the truncated fraction of delta.
  function automatic fixed_t crossing_coord(longint base, longint delta,
                                            longint unsigned ns,
                                            longint unsigned dd);
    longint unsigned mg, off, b;
    mg  = (delta < 0) ? longint'(-delta) : longint'(delta);
    off = scaled_quotient(ns, mg << FB, dd);
    b   = longint'(base) << FB;
    return fixed_t'((delta < 0) ? b - off : b + off);
  endfunction

  // Exact intersection of the two segments of one word.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    longint rx, ry, qx, qy, wx, wy, det, ns, nt;
    longint unsigned mn, md;
    crossing_t c;
    rx = longint'(p.ax1) - longint'(p.ax0);
    ry = longint'(p.ay1) - longint'(p.ay0);
    qx = longint'(p.bx1) - longint'(p.bx0);
    qy = longint'(p.by1) - longint'(p.by0);
    wx = longint'(p.bx0) - longint'(p.ax0);
    wy = longint'(p.by0) - longint'(p.ay0);
    det = rx * qy - ry * qx;
    ns  = wx * qy - wy * qx;
    nt  = wx * ry - wy * rx;
    c.hit = 1'b0;
    c.cx = '0;
    c.cy = '0;
    if (det > 0)
      c.hit = ns >= 0 && ns <= det && nt >= 0 && nt <= det;
    else if (det < 0)
      c.hit = ns <= 0 && ns >= det && nt <= 0 && nt >= det;
    if (c.hit) begin
      mn = (ns < 0) ? -ns : ns;
      md = (det < 0) ? -det : det;
      c.cx = crossing_coord(p.ax0, rx, mn, md);
      c.cy = crossing_coord(p.ay0, ry, mn, md);
    end
    return c;
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span == 0)
      return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic seg_pair_t make_pair(coord_t a, coord_t b, coord_t c, coord_t d,
                                          coord_t e, coord_t f, coord_t g, coord_t h);
    seg_pair_t p;
    p.ax0 = a; p.ay0 = b; p.ax1 = c; p.ay1 = d;
    p.bx0 = e; p.by0 = f; p.bx1 = g; p.by1 = h;
    return p;
  endfunction

  // Random pair built around a likely crossing: B runs through a point of A.
  function automatic seg_pair_t crossing_pair(int span);
    seg_pair_t p;
    longint mx, my, dx, dy;
    p.ax0 = rand_coord(span);
    p.ay0 = rand_coord(span);
    p.ax1 = rand_coord(span);
    p.ay1 = rand_coord(span);
    mx = (longint'(p.ax0) + longint'(p.ax1)) / 2;
    my = (longint'(p.ay0) + longint'(p.ay1)) / 2;
    dx = rand_coord(span) / 2;
    dy = rand_coord(span) / 2;
    p.bx0 = coord_t'(mx - dx);
    p.by0 = coord_t'(my - dy);
    p.bx1 = coord_t'(mx + dx);
    p.by1 = coord_t'(my + dy);
    return p;
  endfunction

  // Stimulus: directed corner cases, then random words of mixed shape.
  initial begin
    seg_pair_t p;
    int span;
    coord_t mx, mn;
    mx = coord_t'(32767);
    mn = coord_t'(-32768);
    // Plain crossing of an X shape.
    pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
    // Parallel segments.
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
    // Collinear overlap still counts as a miss.
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
    // Degenerate segment with both endpoints equal.
    pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
    // Endpoint touches at both parameter ends.
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, -5, 10, 5));
    pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 9));
    // Lines cross but outside the segments.
    pending_pairs.push_back(make_pair(0, 0, 1, 1, 5, 0, 4, 1));
    // Fractional crossing and negative determinant.
    pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, 2, 2, -1));
    pending_pairs.push_back(make_pair(0, 10, 0, -10, 7, 3, -3, -2));
    // Extremes of the coordinate range.
    pending_pairs.push_back(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
    pending_pairs.push_back(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
    pending_pairs.push_back(make_pair(mn, 0, mx, 0, 0, mn, 0, mx));
    pending_pairs.push_back(make_pair(mx, mx, mn, mn, mx, mn, mn, mx));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    pending_pairs.push_back(make_pair(mx, mx, mx, mx, mn, mn, mn, mn));
    pending_pairs.push_back(make_pair(mn, mx, mx, mn, mn, mn, mx, mx));
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(3))
        0: span = 0;
        1: span = 100;
        2: span = 4000;
        default: span = 32767;
      endcase
      if ($urandom_range(9) < 6)
        p = crossing_pair(span);
      else
        p = make_pair(rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span));
      pending_pairs.push_back(p);
    end
  end

  // Reset, the drain pause halfway through and the end of the run.
  initial begin
    rst_n = 1'b0;
    hold_sender = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (words_in >= 700);
    hold_sender = 1'b1;
    wait (expected_crossings.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;
    wait (stimulus_done && expected_crossings.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d words (%0d crossings) against %0d results, %0d mismatches.",
             words_in, hits_seen, words_out, mismatches);
    if (mismatches == 0 && expected_crossings.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Cycle counter guarding against a hung pipeline.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial cycles = 0;

  // Driver: each word waits a random gap, then is held until accepted.
  int gap;
  initial begin
    in_valid = 1'b0;
    {in_a_start_x, in_a_start_y, in_a_end_x, in_a_end_y} = '0;
    {in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y} = '0;
    gap = 0;
    stimulus_done = 1'b0;
    words_in = 0;
  end

  always @(posedge clk) begin
    seg_pair_t p;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
        words_in <= words_in + 1;
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15);
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0 || hold_sender || pending_pairs.size() == 0) begin
          if (gap > 0)
            gap--;
          in_valid <= 1'b0;
          if (pending_pairs.size() == 0)
            stimulus_done <= 1'b1;
        end else begin
          p = pending_pairs[0];
          in_valid <= 1'b1;
          in_a_start_x <= p.ax0;
          in_a_start_y <= p.ay0;
          in_a_end_x <= p.ax1;
          in_a_end_y <= p.ay1;
          in_b_start_x <= p.bx0;
          in_b_start_y <= p.by0;
          in_b_end_x <= p.bx1;
          in_b_end_y <= p.by1;
        end
      end
    end
  end

  // Monitor: random stalls on the result side and field-by-field checks.
  int stall_left;
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    mismatches = 0;
    words_out = 0;
    hits_seen = 0;
  end

  always @(posedge clk) begin
    crossing_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        words_out <= words_out + 1;
        if (expected_crossings.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Unexpected result word: hit=%0b x=%0d y=%0d",
                     out_hit, out_cross_x, out_cross_y);
        end else begin
          e = expected_crossings.pop_front();
          if (e.hit)
            hits_seen <= hits_seen + 1;
          if (out_hit !== e.hit || out_cross_x !== e.cx || out_cross_y !== e.cy) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("Mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                       e.hit, e.cx, e.cy, out_hit, out_cross_x, out_cross_y);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall && $urandom_range(2) == 0)
          stall_left = $urandom_range(15);
      end
    end
  end

endmodule
